// ===== hw/rtl/greedy_vertex_coloring_core_assert.svh =====
// ----------------------------------------------------------------------------
// greedy_vertex_coloring_core assertion macros
// Clocked assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_VERTEX_COLORING_CORE_ASSERT_SVH
`define GREEDY_VERTEX_COLORING_CORE_ASSERT_SVH

// property checked at every rising clk edge outside reset
`define GVC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define GVC_ASSERT_IMP(lbl, ante, cons, msg) \
    `GVC_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define GVC_ASSERT_NXT(lbl, ante, cons, msg) \
    `GVC_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/gvc_pkg.sv =====
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants of the greedy vertex coloring core.
// ----------------------------------------------------------------------------
package gvc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERTEX_W     = 6;
    localparam int NB_W         = 64;
    localparam int COLOR_W      = 7;
    localparam int COLOR_LIMIT  = 64;
    localparam int GROUP_W      = 8;
    localparam int GROUP_N      = COLOR_LIMIT / GROUP_W;
    localparam int GIDX_W       = $clog2(GROUP_W);
    localparam int GSEL_W       = $clog2(GROUP_N);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } gvc_state_t;

endpackage

// ===== hw/rtl/greedy_vertex_coloring_core.sv =====
// ----------------------------------------------------------------------------
// Requests are taken only in idle, one at a time; the core then scans
// L = min(vertex, MAX_VERTICES) earlier vertices, picks and emits a color.
// In the scan the single color memory read port gives one color per cycle.
// The result register lets the next request enter while a result waits.
// Reset clears control and the result valid; color memory is not cleared.
// ----------------------------------------------------------------------------
// greedy_vertex_coloring_core
// First-fit vertex coloring over a color memory with a scan sequencer.
// ----------------------------------------------------------------------------
module greedy_vertex_coloring_core #(
    parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gvc_pkg::VERTEX_W-1:0]  vertex,
    input  logic [gvc_pkg::NB_W-1:0]      earlier_neighbours,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gvc_pkg::VERTEX_W-1:0]  vertex_out,
    output logic [gvc_pkg::COLOR_W-1:0]   color
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [gvc_pkg::COLOR_W-1:0] NV = gvc_pkg::COLOR_W'(MAX_VERTICES);

    gvc_pkg::gvc_state_t state_reg, state_next;

    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [CW-1:0]                     lim_reg, lim_next;
    logic                              in_range_reg, in_range_next;
    logic [gvc_pkg::VERTEX_W-1:0]      v_reg, v_next;
    logic [gvc_pkg::NB_W-1:0]          nb_reg, nb_next;
    logic                              rd_vld_reg, rd_vld_next;
    logic                              nb_bit_reg, nb_bit_next;
    logic [gvc_pkg::COLOR_LIMIT-1:0]   taken_reg, taken_next;
    logic                              out_valid_reg, out_valid_next;
    logic [gvc_pkg::VERTEX_W-1:0]      vertex_out_reg, vertex_out_next;
    logic [gvc_pkg::COLOR_W-1:0]       color_reg, color_next;

    logic                              rd_en;
    logic                              wr_en;
    logic                              pick_load;
    logic [gvc_pkg::COLOR_W-1:0]       rd_color;
    logic [gvc_pkg::COLOR_W-1:0]       pick_color;
    logic [gvc_pkg::COLOR_W-1:0]       v_ext;
    logic [gvc_pkg::COLOR_W-1:0]       col_m1;

    gvc_ram #(
        .WIDTH (gvc_pkg::COLOR_W),
        .DEPTH (MAX_VERTICES)
    ) u_color_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (v_reg[AW-1:0]),
        .wdata (pick_color),
        .re    (rd_en),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_color)
    );

    gvc_pick u_pick (
        .clk   (clk),
        .load  (pick_load),
        .taken (taken_reg),
        .color (pick_color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gvc_pkg::ST_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        lim_reg        <= lim_next;
        in_range_reg   <= in_range_next;
        v_reg          <= v_next;
        nb_reg         <= nb_next;
        nb_bit_reg     <= nb_bit_next;
        taken_reg      <= taken_next;
        vertex_out_reg <= vertex_out_next;
        color_reg      <= color_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        lim_next        = lim_reg;
        in_range_next   = in_range_reg;
        v_next          = v_reg;
        nb_next         = nb_reg;
        nb_bit_next     = nb_bit_reg;
        rd_vld_next     = 1'b0;
        taken_next      = taken_reg;
        out_valid_next  = out_valid_reg;
        vertex_out_next = vertex_out_reg;
        color_next      = color_reg;
        in_ready        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        pick_load       = 1'b0;
        v_ext           = {1'b0, vertex};
        col_m1          = rd_color - gvc_pkg::COLOR_W'(1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // neighbour color returning from memory
        if (rd_vld_reg && nb_bit_reg && rd_color != '0
            && rd_color <= gvc_pkg::COLOR_W'(gvc_pkg::COLOR_LIMIT))
        begin
            taken_next[col_m1[gvc_pkg::VERTEX_W-1:0]] = 1'b1;
        end

        case (state_reg)
            gvc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    v_next     = vertex;
                    nb_next    = earlier_neighbours;
                    cnt_next   = '0;
                    taken_next = '0;
                    if (v_ext < NV)
                    begin
                        in_range_next = 1'b1;
                        lim_next      = CW'(v_ext);
                    end
                    else
                    begin
                        in_range_next = 1'b0;
                        lim_next      = CW'(MAX_VERTICES);
                    end
                    state_next = gvc_pkg::ST_SCAN;
                end
            end
            gvc_pkg::ST_SCAN:
            begin
                if (cnt_reg != lim_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    nb_bit_next = nb_reg[0];
                    nb_next     = nb_reg >> 1;
                    cnt_next    = cnt_reg + CW'(1);
                end
                else
                begin
                    // last returning color lands in taken_reg at this edge
                    state_next = gvc_pkg::ST_PICK;
                end
            end
            gvc_pkg::ST_PICK:
            begin
                pick_load  = 1'b1;
                state_next = gvc_pkg::ST_EMIT;
            end
            gvc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    vertex_out_next = v_reg;
                    color_next      = pick_color;
                    wr_en           = in_range_reg;
                    state_next      = gvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gvc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign vertex_out = vertex_out_reg;
    assign color      = color_reg;

endmodule

// ===== hw/rtl/gvc_ram.sv =====
// ----------------------------------------------------------------------------
// gvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gvc_ram #(
    parameter int WIDTH = gvc_pkg::COLOR_W,
    parameter int DEPTH = gvc_pkg::MAX_VERTICES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/gvc_pick.sv =====
// ----------------------------------------------------------------------------
// gvc_pick
// Two-step first-free search over the taken-color mask.
// ----------------------------------------------------------------------------
module gvc_pick (
    input  logic                                clk,
    input  logic                                load,
    input  logic [gvc_pkg::COLOR_LIMIT-1:0]     taken,
    output logic [gvc_pkg::COLOR_W-1:0]         color
);

    logic [gvc_pkg::GROUP_N-1:0] grp_free_reg;
    logic [gvc_pkg::GROUP_N-1:0] grp_free_next;
    logic [gvc_pkg::GIDX_W-1:0]  grp_idx_reg  [gvc_pkg::GROUP_N];
    logic [gvc_pkg::GIDX_W-1:0]  grp_idx_next [gvc_pkg::GROUP_N];

    // per group: any free color, and lowest free position
    always_comb
    begin
        for (int g = 0; g < gvc_pkg::GROUP_N; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int b = gvc_pkg::GROUP_W - 1; b >= 0; b--)
            begin
                if (!taken[g * gvc_pkg::GROUP_W + b])
                begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = gvc_pkg::GIDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_free_reg <= grp_free_next;
            grp_idx_reg  <= grp_idx_next;
        end
    end

    // lowest group with a free color; colors count from 1
    always_comb
    begin
        color = gvc_pkg::COLOR_W'(gvc_pkg::COLOR_LIMIT);
        for (int g = gvc_pkg::GROUP_N - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                color = gvc_pkg::COLOR_W'({gvc_pkg::GSEL_W'(g), grp_idx_reg[g]})
                        + gvc_pkg::COLOR_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/gvc_checker.sv =====
// ----------------------------------------------------------------------------
// gvc_checker
// Port-level checks of the greedy vertex coloring core, bound to the top.
// ----------------------------------------------------------------------------
`include "greedy_vertex_coloring_core_assert.svh"

module gvc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [gvc_pkg::VERTEX_W-1:0]  vertex,
    input logic [gvc_pkg::NB_W-1:0]      earlier_neighbours,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [gvc_pkg::VERTEX_W-1:0]  vertex_out,
    input logic [gvc_pkg::COLOR_W-1:0]   color
);

    logic [gvc_pkg::COLOR_W-1:0] color_cap;

    // a vertex has at most vertex_out earlier neighbours
    assign color_cap = {1'b0, vertex_out} + gvc_pkg::COLOR_W'(1);

    `GVC_ASSERT_NXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(vertex) && $stable(earlier_neighbours),
        "request dropped or changed while waiting")
    `GVC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(vertex_out) && $stable(color),
        "result dropped or changed while stalled")
    `GVC_ASSERT_IMP(a_color_range, out_valid, color != '0 && color <= color_cap,
        "color outside 1..vertex+1")
    `GVC_ASSERT_IMP(a_first_color, out_valid && vertex_out == '0,
        color == gvc_pkg::COLOR_W'(1), "vertex 0 not given color 1")
    `GVC_ASSERT_NXT(a_one_at_time, in_valid && in_ready, !in_ready,
        "request taken while another is in work")

endmodule

bind greedy_vertex_coloring_core gvc_checker u_gvc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .vertex             (vertex),
    .earlier_neighbours (earlier_neighbours),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .vertex_out         (vertex_out),
    .color              (color)
);
